### rtl/dbmc_pkg.sv
// ----------------------------------------------------------------------------
// Display brightness mode controller package
// Transaction types, action and mode codes, register map and reset values.
// ----------------------------------------------------------------------------
package dbmc_pkg;

  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int TIMEOUT_MS_W = 26;

  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  localparam logic [7:0]  LEVEL_RST            = 8'd255;
  localparam logic        ENGINE_ENABLE_RST    = 1'b1;
  localparam logic [7:0]  DAY_BRIGHTNESS_RST   = 8'd200;
  localparam logic [7:0]  ALERT_BRIGHTNESS_RST = 8'd255;
  localparam logic [7:0]  MUTE_BRIGHTNESS_RST  = 8'd64;
  localparam logic [7:0]  IDLE_BRIGHTNESS_RST  = 8'd32;
  localparam logic [15:0] IDLE_TIMEOUT_RST     = 16'd0;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ACTIVITY = 2'd1,
    ACT_SET_DAY  = 2'd2,
    ACT_RESTART  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_DAY   = 2'd0,
    MODE_IDLE  = 2'd1,
    MODE_BOOST = 2'd2,
    MODE_MUTE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_ENGINE_ENABLE    = 3'd0,
    REG_DAY_BRIGHTNESS   = 3'd1,
    REG_ALERT_BRIGHTNESS = 3'd2,
    REG_MUTE_BRIGHTNESS  = 3'd3,
    REG_IDLE_BRIGHTNESS  = 3'd4,
    REG_IDLE_TIMEOUT     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] now_ms;
    logic        alerts_present;
    logic        muted;
    logic [7:0]  new_day_base;
  } in_item_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic       brightness_changed;
    mode_t      mode;
  } out_item_t;

endpackage

### rtl/display_brightness_mode_controller_unit.sv
// ----------------------------------------------------------------------------
// Display brightness mode controller unit
// Selects the display brightness from day, idle dim, alert boosted and alert
// muted modes, driven by tick, activity, day base and restart transactions.
//
// The input channel (in_valid, in_ready, in_data) carries one action per
// transaction. Every input transaction produces exactly one result
// transaction on the output channel (out_valid, out_ready, out_data) with the
// new level, a changed flag and the mode.
// An accepted transaction lands in an input register; its result is computed
// from that register and the state and lands in the output register once that
// register is empty or its result is being taken. One transaction per cycle is
// sustained while the receiver takes every result; the state update is a
// single pass of short compare and subtract logic.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more transaction before in_ready drops.
// Reset loads the register reset values, sets the mode to day, the level to
// 255 and the day base to 200, and empties both registers. The configuration
// port must be written only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module display_brightness_mode_controller_unit
  import dbmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic                    engine_en_r;
  logic [7:0]              day_bright_r;
  logic [7:0]              alert_bright_r;
  logic [7:0]              mute_bright_r;
  logic [7:0]              idle_bright_r;
  logic [15:0]             idle_timeout_r;
  logic [TIMEOUT_MS_W-1:0] timeout_ms_r;

  mode_t                   mode_r;
  mode_t                   mode_nxt;
  logic [7:0]              level_r;
  logic [7:0]              level_nxt;
  logic [7:0]              day_base_r;
  logic [7:0]              day_base_nxt;
  logic [31:0]             last_act_r;
  logic [31:0]             last_act_nxt;
  logic                    prev_alert_r;
  logic                    prev_alert_nxt;

  logic                    in_valid_r;
  in_item_t                in_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  logic                    cfg_wr;
  reg_idx_t                cfg_idx;
  logic                    advance;
  logic [31:0]             elapsed;
  logic                    idle_expired;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_ENGINE_ENABLE:    cfg_prdata = {31'd0, engine_en_r};
      REG_DAY_BRIGHTNESS:   cfg_prdata = {24'd0, day_bright_r};
      REG_ALERT_BRIGHTNESS: cfg_prdata = {24'd0, alert_bright_r};
      REG_MUTE_BRIGHTNESS:  cfg_prdata = {24'd0, mute_bright_r};
      REG_IDLE_BRIGHTNESS:  cfg_prdata = {24'd0, idle_bright_r};
      REG_IDLE_TIMEOUT:     cfg_prdata = {16'd0, idle_timeout_r};
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engine_en_r    <= ENGINE_ENABLE_RST;
      day_bright_r   <= DAY_BRIGHTNESS_RST;
      alert_bright_r <= ALERT_BRIGHTNESS_RST;
      mute_bright_r  <= MUTE_BRIGHTNESS_RST;
      idle_bright_r  <= IDLE_BRIGHTNESS_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      timeout_ms_r   <= '0;
    end else begin
      timeout_ms_r <= {{(TIMEOUT_MS_W-16){1'b0}}, idle_timeout_r}
                      * TIMEOUT_MS_W'(MS_PER_SEC);
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_ENGINE_ENABLE:    engine_en_r    <= cfg_pwdata[0];
          REG_DAY_BRIGHTNESS:   day_bright_r   <= cfg_pwdata[7:0];
          REG_ALERT_BRIGHTNESS: alert_bright_r <= cfg_pwdata[7:0];
          REG_MUTE_BRIGHTNESS:  mute_bright_r  <= cfg_pwdata[7:0];
          REG_IDLE_BRIGHTNESS:  idle_bright_r  <= cfg_pwdata[7:0];
          REG_IDLE_TIMEOUT:     idle_timeout_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign elapsed      = in_r.now_ms - last_act_r;
  assign idle_expired = (timeout_ms_r != '0) &&
                        (elapsed >= {{(32-TIMEOUT_MS_W){1'b0}}, timeout_ms_r});

  always_comb begin
    mode_nxt       = mode_r;
    level_nxt      = level_r;
    day_base_nxt   = day_base_r;
    last_act_nxt   = last_act_r;
    prev_alert_nxt = prev_alert_r;
    case (in_r.action)
      ACT_TICK: begin
        prev_alert_nxt = in_r.alerts_present;
        if (engine_en_r) begin
          if (in_r.alerts_present) begin
            last_act_nxt = in_r.now_ms;
            if (in_r.muted) begin
              if (mode_r != MODE_MUTE) begin
                mode_nxt  = MODE_MUTE;
                level_nxt = mute_bright_r;
              end
            end else if (mode_r != MODE_BOOST) begin
              mode_nxt  = MODE_BOOST;
              level_nxt = alert_bright_r;
            end
          end else begin
            if (prev_alert_r) begin
              mode_nxt  = MODE_DAY;
              level_nxt = day_base_r;
            end
            if (mode_nxt != MODE_IDLE && idle_expired) begin
              mode_nxt  = MODE_IDLE;
              level_nxt = idle_bright_r;
            end
          end
        end
      end
      ACT_ACTIVITY: begin
        last_act_nxt = in_r.now_ms;
        if (mode_r == MODE_IDLE) begin
          mode_nxt  = MODE_DAY;
          level_nxt = day_base_r;
        end
      end
      ACT_SET_DAY: begin
        last_act_nxt = in_r.now_ms;
        day_base_nxt = in_r.new_day_base;
        if (mode_r == MODE_IDLE || mode_r == MODE_DAY) begin
          mode_nxt  = MODE_DAY;
          level_nxt = in_r.new_day_base;
        end
      end
      default: begin
        last_act_nxt   = in_r.now_ms;
        day_base_nxt   = day_bright_r;
        level_nxt      = LEVEL_RST;
        mode_nxt       = MODE_DAY;
        prev_alert_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= MODE_DAY;
      level_r      <= LEVEL_RST;
      day_base_r   <= DAY_BRIGHTNESS_RST;
      last_act_r   <= '0;
      prev_alert_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r  <= 1'b1;
        mode_r       <= mode_nxt;
        level_r      <= level_nxt;
        day_base_r   <= day_base_nxt;
        last_act_r   <= last_act_nxt;
        prev_alert_r <= prev_alert_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r.brightness         <= level_nxt;
      out_r.brightness_changed <= (level_nxt != level_r);
      out_r.mode               <= mode_nxt;
    end
  end

endmodule
